// File: sv/grid_dfs_explorer_unit_macros.svh
// Assertion macros shared by the explorer RTL.
`ifndef GRID_DFS_EXPLORER_UNIT_MACROS_SVH
`define GRID_DFS_EXPLORER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define GDE_ASSERT_IMPL(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define GDE_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/gde_pkg.sv
// Types and constants of the grid depth-first explorer.
package gde_pkg;

    // arena side limit; larger arena_size values are clamped to it
    localparam logic [3:0] GRID_MAX = 4'd8;

    // configuration register indexes
    localparam logic [2:0] REG_ARENA_SIZE      = 3'd0;
    localparam logic [2:0] REG_START_X         = 3'd1;
    localparam logic [2:0] REG_START_Y         = 3'd2;
    localparam logic [2:0] REG_START_HEADING   = 3'd3;
    localparam logic [2:0] REG_GOAL_X          = 3'd4;
    localparam logic [2:0] REG_GOAL_Y          = 3'd5;
    localparam logic [2:0] REG_CELLS_TO_VISIT  = 3'd6;
    localparam logic [2:0] REG_PREMARKED_CELLS = 3'd7;

    // headings
    localparam logic [1:0] HD_NORTH = 2'd0;
    localparam logic [1:0] HD_EAST  = 2'd1;
    localparam logic [1:0] HD_SOUTH = 2'd2;
    localparam logic [1:0] HD_WEST  = 2'd3;

    localparam logic [1:0] TURN_NONE = 2'd0;

    // result status codes
    localparam logic [1:0] ST_EXPLORE   = 2'd0;
    localparam logic [1:0] ST_BACKTRACK = 2'd1;
    localparam logic [1:0] ST_FINISHED  = 2'd2;
    localparam logic [1:0] ST_ERROR     = 2'd3;

    typedef enum logic [2:0] {
        PH_RUN = 3'b001,
        PH_FIN = 3'b010,
        PH_ERR = 3'b100
    } phase_t;

    typedef struct packed {
        logic [3:0]  arena_size;
        logic [2:0]  start_x;
        logic [2:0]  start_y;
        logic [1:0]  start_heading;
        logic [2:0]  goal_x;
        logic [2:0]  goal_y;
        logic [6:0]  cells_to_visit;
        logic [63:0] premarked_cells;
    } cfg_t;

    typedef struct packed {
        logic [2:0]  cur_x;
        logic [2:0]  cur_y;
        logic [1:0]  heading;
        logic [63:0] visited;
        logic [6:0]  visit_cnt;
        phase_t      phase;
    } state_t;

    typedef struct packed {
        logic       push;
        logic [5:0] loc;    // x in [5:3], y in [2:0]
    } stack_op_t;

    typedef struct packed {
        logic [1:0] turn_cmd;
        logic       drive_cell;
        logic [2:0] pos_x;
        logic [2:0] pos_y;
        logic [1:0] facing;
        logic [1:0] status;
        logic [6:0] count_out;
    } result_t;

    localparam cfg_t CFG_RST = '{
        arena_size:      4'd6,
        start_x:         3'd0,
        start_y:         3'd0,
        start_heading:   2'd0,
        goal_x:          3'd5,
        goal_y:          3'd5,
        cells_to_visit:  7'd21,
        premarked_cells: 64'h0000_1F1F_1F00_0000
    };

    // premarked cells plus the start cell (0,0)
    localparam logic [63:0] VISITED_RST = 64'h0000_1F1F_1F00_0001;

endpackage

// File: sv/gde_stack.sv
// Return-cell stack: memory with registered top-of-stack read and push bypass.
module gde_stack #(
    parameter int DEPTH = 64,
    localparam int CW = $clog2(DEPTH + 1),
    localparam int AW = $clog2(DEPTH)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  gde_pkg::stack_op_t  op,
    input  logic [CW-1:0]       cnt_next,
    output logic [5:0]          top
);

    logic [5:0]    mem [DEPTH];
    logic [AW-1:0] addr;
    logic [5:0]    rd_reg;
    logic          byp_reg;
    logic [5:0]    byp_loc_reg;

    // top entry after this edge sits at cnt_next - 1; a push writes there too
    assign addr = (cnt_next == '0) ? '0 : AW'(cnt_next - CW'(1));

    always_ff @(posedge clk)
    begin
        if (op.push)
        begin
            mem[addr] <= op.loc;
        end
        rd_reg      <= mem[addr];
        byp_loc_reg <= op.loc;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byp_reg <= 1'b0;
        end
        else
        begin
            byp_reg <= op.push;
        end
    end

    assign top = byp_reg ? byp_loc_reg : rd_reg;

endmodule

// File: sv/gde_step.sv
// Next-state and result logic for one wall reading.
module gde_step #(
    parameter int STACK_DEPTH = 64,
    localparam int CW = $clog2(STACK_DEPTH + 1)
) (
    input  gde_pkg::cfg_t       cfg,
    input  gde_pkg::state_t     st,
    input  logic [CW-1:0]       stack_cnt,
    input  logic [5:0]          stack_top,
    input  logic                restart,
    input  logic [2:0]          walls,
    output gde_pkg::state_t     st_next,
    output logic [CW-1:0]       stack_cnt_next,
    output gde_pkg::stack_op_t  stack_op,
    output gde_pkg::result_t    result
);

    function automatic logic [63:0] cell_bit(input logic [2:0] x, input logic [2:0] y);
        return 64'd1 << {x, y};
    endfunction

    // neighbor cell one step along h, wrapping in 3 bits
    function automatic logic [5:0] step_pos(input logic [1:0] h, input logic [2:0] x,
                                            input logic [2:0] y);
        logic [2:0] nx;
        logic [2:0] ny;
        nx = x;
        ny = y;
        case (h)
            gde_pkg::HD_NORTH: ny = y + 3'd1;
            gde_pkg::HD_EAST:  nx = x + 3'd1;
            gde_pkg::HD_SOUTH: ny = y - 3'd1;
            gde_pkg::HD_WEST:  nx = x - 3'd1;
            default: ;
        endcase
        return {nx, ny};
    endfunction

    function automatic logic nb_ok(input logic [1:0] h, input logic [2:0] x,
                                   input logic [2:0] y, input logic [3:0] size,
                                   input logic [63:0] vis, input logic [2:0] gx,
                                   input logic [2:0] gy, input logic goal_closed);
        logic [3:0] nx;
        logic [3:0] ny;
        logic       neg;
        nx  = {1'b0, x};
        ny  = {1'b0, y};
        neg = 1'b0;
        case (h)
            gde_pkg::HD_NORTH: ny = ny + 4'd1;
            gde_pkg::HD_EAST:  nx = nx + 4'd1;
            gde_pkg::HD_SOUTH:
            begin
                neg = (y == 3'd0);
                ny  = ny - 4'd1;
            end
            gde_pkg::HD_WEST:
            begin
                neg = (x == 3'd0);
                nx  = nx - 4'd1;
            end
            default: ;
        endcase
        return !neg && (nx < size) && (ny < size) && !vis[{nx[2:0], ny[2:0]}] &&
               !(nx[2:0] == gx && ny[2:0] == gy && goal_closed);
    endfunction

    logic [3:0] size;
    logic       goal_closed;
    logic [1:0] h_r, h_f, h_l;
    logic       ok_r, ok_f, ok_l;
    logic       found;
    logic [1:0] target;
    logic [2:0] px, py;
    logic [1:0] back;
    logic       finish_pre;
    logic [1:0] turn;
    logic       drive;
    logic [1:0] status;
    logic [5:0] npos;

    assign size        = (cfg.arena_size > gde_pkg::GRID_MAX) ? gde_pkg::GRID_MAX
                                                               : cfg.arena_size;
    assign goal_closed = ({1'b0, st.visit_cnt} + 8'd1) < {1'b0, cfg.cells_to_visit};

    assign h_r = st.heading + 2'd1;
    assign h_f = st.heading;
    assign h_l = st.heading + 2'd3;

    assign ok_r = !walls[0] && nb_ok(h_r, st.cur_x, st.cur_y, size, st.visited,
                                     cfg.goal_x, cfg.goal_y, goal_closed);
    assign ok_f = !walls[1] && nb_ok(h_f, st.cur_x, st.cur_y, size, st.visited,
                                     cfg.goal_x, cfg.goal_y, goal_closed);
    assign ok_l = !walls[2] && nb_ok(h_l, st.cur_x, st.cur_y, size, st.visited,
                                     cfg.goal_x, cfg.goal_y, goal_closed);

    assign found  = ok_r || ok_f || ok_l;
    assign target = ok_r ? h_r : (ok_f ? h_f : h_l);

    // backtrack heading toward popped cell, x compared first
    assign px = stack_top[5:3];
    assign py = stack_top[2:0];
    always_comb
    begin
        if (px > st.cur_x)
            back = gde_pkg::HD_EAST;
        else if (px < st.cur_x)
            back = gde_pkg::HD_WEST;
        else if (py > st.cur_y)
            back = gde_pkg::HD_NORTH;
        else if (py < st.cur_y)
            back = gde_pkg::HD_SOUTH;
        else
            back = st.heading;
    end

    assign finish_pre = (st.visit_cnt == cfg.cells_to_visit) &&
                        (st.cur_x == cfg.goal_x) && (st.cur_y == cfg.goal_y);

    always_comb
    begin
        st_next        = st;
        stack_cnt_next = stack_cnt;
        stack_op.push  = 1'b0;
        stack_op.loc   = {st.cur_x, st.cur_y};
        turn           = gde_pkg::TURN_NONE;
        drive          = 1'b0;
        status         = gde_pkg::ST_EXPLORE;
        npos           = '0;

        if (restart)
        begin
            st_next.cur_x     = cfg.start_x;
            st_next.cur_y     = cfg.start_y;
            st_next.heading   = cfg.start_heading;
            st_next.visited   = cfg.premarked_cells | cell_bit(cfg.start_x, cfg.start_y);
            st_next.visit_cnt = 7'd1;
            st_next.phase     = gde_pkg::PH_RUN;
            stack_cnt_next    = '0;
        end
        else if (st.phase == gde_pkg::PH_FIN)
        begin
            status = gde_pkg::ST_FINISHED;
        end
        else if (st.phase != gde_pkg::PH_RUN)
        begin
            status = gde_pkg::ST_ERROR;
        end
        else if (finish_pre)
        begin
            st_next.phase = gde_pkg::PH_FIN;
            status        = gde_pkg::ST_FINISHED;
        end
        else if (found)
        begin
            // push is dropped on a full stack, the move still happens
            if (stack_cnt < CW'(STACK_DEPTH))
            begin
                stack_op.push  = 1'b1;
                stack_cnt_next = stack_cnt + CW'(1);
            end
            turn              = target - st.heading;
            npos              = step_pos(target, st.cur_x, st.cur_y);
            st_next.heading   = target;
            st_next.cur_x     = npos[5:3];
            st_next.cur_y     = npos[2:0];
            st_next.visited   = st.visited | cell_bit(npos[5:3], npos[2:0]);
            st_next.visit_cnt = (st.visit_cnt == 7'd127) ? st.visit_cnt
                                                         : st.visit_cnt + 7'd1;
            drive             = 1'b1;
            status            = gde_pkg::ST_EXPLORE;
        end
        else if (stack_cnt == '0)
        begin
            st_next.phase = gde_pkg::PH_ERR;
            status        = gde_pkg::ST_ERROR;
        end
        else
        begin
            stack_cnt_next  = stack_cnt - CW'(1);
            turn            = back - st.heading;
            npos            = step_pos(back, st.cur_x, st.cur_y);
            st_next.heading = back;
            st_next.cur_x   = npos[5:3];
            st_next.cur_y   = npos[2:0];
            drive           = 1'b1;
            status          = gde_pkg::ST_BACKTRACK;
        end

        // arrival on the goal with the full count ends the run
        if (drive && st_next.visit_cnt == cfg.cells_to_visit &&
            st_next.cur_x == cfg.goal_x && st_next.cur_y == cfg.goal_y)
        begin
            st_next.phase = gde_pkg::PH_FIN;
            status        = gde_pkg::ST_FINISHED;
        end
    end

    assign result.turn_cmd   = turn;
    assign result.drive_cell = drive;
    assign result.pos_x      = st_next.cur_x;
    assign result.pos_y      = st_next.cur_y;
    assign result.facing     = st_next.heading;
    assign result.status     = status;
    assign result.count_out  = st_next.visit_cnt;

endmodule

// File: sv/grid_dfs_explorer_unit.sv
// Top level of the grid depth-first maze explorer.
//
// Usage:
//  - Slave stream takes one wall reading per request: tdata[2:0] = walls
//    (bit0 right, bit1 front, bit2 left, 1 = blocked), tuser = restart.
//  - Master stream returns one command per request: turn, drive flag, new
//    pose, status and visit count (layout beside m_axis_tdata).
//  - A request accepted into the input register is evaluated into the output
//    register once it is free; m_axis_tvalid comes from the output register.
//  - Throughput: one request per cycle while m_axis_tready is high. Position,
//    heading, visited map and stack pointer update together on evaluation;
//    the stack top comes from a registered memory read that is re-aimed each
//    edge at the new top, with a bypass for a push in the previous cycle.
//  - A stalled master side holds the result; the input register still takes
//    one more request, then s_axis_tready drops until the result drains.
//  - Reset loads the register defaults and starts a run at the start pose.
//    The return stack needs no clearing pass: only pushed entries are read.
//  - Config registers are written through cfg_wr_en/cfg_index/cfg_data while
//    the block is idle; start pose and premarked map take effect on restart.
module grid_dfs_explorer_unit #(
    parameter int STACK_DEPTH = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [2:0] walls, [7:3] zero
    input  logic        s_axis_tuser,   // [0] restart
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [1:0] turn_cmd, [2] drive_cell, [5:3] pos_x, [8:6] pos_y, [10:9] facing,
    // [12:11] status, [19:13] count_out, [23:20] zero
    output logic [23:0] m_axis_tdata,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data
);

    localparam int CW = $clog2(STACK_DEPTH + 1);

    gde_pkg::cfg_t      cfg_reg, cfg_next;
    gde_pkg::state_t    st_reg, st_next;
    logic [CW-1:0]      stack_cnt_reg, stack_cnt_next;

    logic               in_valid_reg, in_valid_next;
    logic               in_restart_reg, in_restart_next;
    logic [2:0]         in_walls_reg, in_walls_next;
    logic               out_valid_reg, out_valid_next;
    gde_pkg::result_t   out_reg, out_next;

    gde_pkg::state_t    step_st;
    logic [CW-1:0]      step_cnt;
    gde_pkg::stack_op_t step_op;
    gde_pkg::stack_op_t stack_op;
    gde_pkg::result_t   step_res;
    logic [5:0]         stack_top;

    logic               out_free;
    logic               proc;
    logic               s_accept;

    // assertion helpers
    logic               fin_hold;
    logic [7:0]         pose_now;
    logic               in_wait;
    logic [3:0]         in_pl;

    // handshake: the output register frees when empty or being drained
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign proc          = in_valid_reg && out_free;
    assign s_axis_tready = !in_valid_reg || out_free;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    gde_step #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_step (
        .cfg            (cfg_reg),
        .st             (st_reg),
        .stack_cnt      (stack_cnt_reg),
        .stack_top      (stack_top),
        .restart        (in_restart_reg),
        .walls          (in_walls_reg),
        .st_next        (step_st),
        .stack_cnt_next (step_cnt),
        .stack_op       (step_op),
        .result         (step_res)
    );

    assign stack_op.push = proc && step_op.push;
    assign stack_op.loc  = step_op.loc;

    gde_stack #(
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .clk      (clk),
        .rst_n    (rst_n),
        .op       (stack_op),
        .cnt_next (stack_cnt_next),
        .top      (stack_top)
    );

    // config writes
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            case (cfg_index)
                gde_pkg::REG_ARENA_SIZE:      cfg_next.arena_size      = cfg_data[3:0];
                gde_pkg::REG_START_X:         cfg_next.start_x         = cfg_data[2:0];
                gde_pkg::REG_START_Y:         cfg_next.start_y         = cfg_data[2:0];
                gde_pkg::REG_START_HEADING:   cfg_next.start_heading   = cfg_data[1:0];
                gde_pkg::REG_GOAL_X:          cfg_next.goal_x          = cfg_data[2:0];
                gde_pkg::REG_GOAL_Y:          cfg_next.goal_y          = cfg_data[2:0];
                gde_pkg::REG_CELLS_TO_VISIT:  cfg_next.cells_to_visit  = cfg_data[6:0];
                gde_pkg::REG_PREMARKED_CELLS: cfg_next.premarked_cells = cfg_data;
                default: ;
            endcase
        end
    end

    // pipeline control and state
    always_comb
    begin
        in_valid_next   = s_accept ? 1'b1 : (proc ? 1'b0 : in_valid_reg);
        in_restart_next = s_accept ? s_axis_tuser : in_restart_reg;
        in_walls_next   = s_accept ? s_axis_tdata[2:0] : in_walls_reg;
        out_valid_next  = proc ? 1'b1 : (m_axis_tready ? 1'b0 : out_valid_reg);
        out_next        = proc ? step_res : out_reg;
        st_next         = proc ? step_st : st_reg;
        stack_cnt_next  = proc ? step_cnt : stack_cnt_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg           <= gde_pkg::CFG_RST;
            st_reg.cur_x      <= gde_pkg::CFG_RST.start_x;
            st_reg.cur_y      <= gde_pkg::CFG_RST.start_y;
            st_reg.heading    <= gde_pkg::CFG_RST.start_heading;
            st_reg.visited    <= gde_pkg::VISITED_RST;
            st_reg.visit_cnt  <= 7'd1;
            st_reg.phase      <= gde_pkg::PH_RUN;
            stack_cnt_reg     <= '0;
            in_valid_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            cfg_reg       <= cfg_next;
            st_reg        <= st_next;
            stack_cnt_reg <= stack_cnt_next;
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        in_restart_reg <= in_restart_next;
        in_walls_reg   <= in_walls_next;
        out_reg        <= out_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'd0, out_reg.count_out, out_reg.status, out_reg.facing,
                            out_reg.pos_y, out_reg.pos_x, out_reg.drive_cell,
                            out_reg.turn_cmd};

    assign fin_hold = (st_reg.phase == gde_pkg::PH_FIN) && !(proc && in_restart_reg);
    assign pose_now = {st_reg.cur_x, st_reg.cur_y, st_reg.heading};
    assign in_wait  = in_valid_reg && !proc;
    assign in_pl    = {in_walls_reg, in_restart_reg};

`include "grid_dfs_explorer_unit_macros.svh"

    // stack pointer never passes the memory depth
    `GDE_ASSERT_IMPL(a_stack_bound, 1'b1, stack_cnt_reg <= CW'(STACK_DEPTH), "stack overflow")

    // a finished run keeps its pose until a restart is evaluated
    `GDE_ASSERT_NEXT(a_fin_hold, fin_hold, $stable(pose_now), "pose moved after finish")

    // visit count is at least one in every state
    `GDE_ASSERT_IMPL(a_count_nonzero, 1'b1, st_reg.visit_cnt != 7'd0, "visit count is zero")

    // a request waiting in the input register is kept until evaluated
    `GDE_ASSERT_NEXT(a_in_hold, in_wait, in_valid_reg && $stable(in_pl), "pending request lost")

endmodule

// File: verif/tb_top.sv
// Self-checking testbench for the grid depth-first maze explorer.
module tb_top;
    import gde_pkg::*;

    localparam int RETURN_DEPTH = 64;

    // Tracks the explorer's state and configuration, predicts the command each
    // wall reading must produce, and checks the returned commands in order.
    class maze_scoreboard;
        logic [3:0]  arena_size;
        logic [2:0]  start_x;
        logic [2:0]  start_y;
        logic [1:0]  start_heading;
        logic [2:0]  goal_x;
        logic [2:0]  goal_y;
        logic [6:0]  cells_to_visit;
        logic [63:0] premarked;

        logic [2:0]  cur_x;
        logic [2:0]  cur_y;
        logic [1:0]  heading;
        logic [63:0] visited;
        logic [5:0]  return_cells [RETURN_DEPTH];
        int          stack_ptr;
        logic [6:0]  visit_cnt;
        phase_t      phase;

        result_t     expected_cmds [$];
        int          fail_count;

        function new();
            arena_size     = CFG_RST.arena_size;
            start_x        = CFG_RST.start_x;
            start_y        = CFG_RST.start_y;
            start_heading  = CFG_RST.start_heading;
            goal_x         = CFG_RST.goal_x;
            goal_y         = CFG_RST.goal_y;
            cells_to_visit = CFG_RST.cells_to_visit;
            premarked      = CFG_RST.premarked_cells;
            fail_count     = 0;
            reload();
        endfunction

        function void write_reg(logic [2:0] idx, logic [63:0] data);
            case (idx)
                REG_ARENA_SIZE:      arena_size = data[3:0];
                REG_START_X:         start_x = data[2:0];
                REG_START_Y:         start_y = data[2:0];
                REG_START_HEADING:   start_heading = data[1:0];
                REG_GOAL_X:          goal_x = data[2:0];
                REG_GOAL_Y:          goal_y = data[2:0];
                REG_CELLS_TO_VISIT:  cells_to_visit = data[6:0];
                REG_PREMARKED_CELLS: premarked = data;
                default: ;
            endcase
        endfunction

        function logic [63:0] cell_mask(logic [2:0] x, logic [2:0] y);
            return 64'd1 << {x, y};
        endfunction

        function void reload();
            cur_x     = start_x;
            cur_y     = start_y;
            heading   = start_heading;
            visited   = premarked | cell_mask(start_x, start_y);
            stack_ptr = 0;
            visit_cnt = 7'd1;
            phase     = PH_RUN;
        endfunction

        function int step_x(logic [1:0] h);
            if (h == HD_EAST) return 1;
            if (h == HD_WEST) return -1;
            return 0;
        endfunction

        function int step_y(logic [1:0] h);
            if (h == HD_NORTH) return 1;
            if (h == HD_SOUTH) return -1;
            return 0;
        endfunction

        function bit goal_done();
            return visit_cnt == cells_to_visit && cur_x == goal_x && cur_y == goal_y;
        endfunction

        // open walls aside: in bounds, unvisited, and goal only as the last cell
        function bit can_enter(logic [1:0] h);
            int side;
            int nx;
            int ny;
            side = (arena_size > GRID_MAX) ? GRID_MAX : arena_size;
            nx = int'(cur_x) + step_x(h);
            ny = int'(cur_y) + step_y(h);
            if (nx < 0 || nx >= side || ny < 0 || ny >= side)
                return 0;
            if (visited[nx * 8 + ny])
                return 0;
            if (nx == int'(goal_x) && ny == int'(goal_y) &&
                int'(visit_cnt) + 1 < int'(cells_to_visit))
                return 0;
            return 1;
        endfunction

        function void move_ahead();
            cur_x = 3'(int'(cur_x) + step_x(heading));
            cur_y = 3'(int'(cur_y) + step_y(heading));
        endfunction

        function void push_cmd(logic [1:0] turn, logic drv, logic [1:0] st);
            result_t r;
            r.turn_cmd   = turn;
            r.drive_cell = drv;
            r.pos_x      = cur_x;
            r.pos_y      = cur_y;
            r.facing     = heading;
            r.status     = st;
            r.count_out  = visit_cnt;
            expected_cmds.push_back(r);
        endfunction

        function void note_reading(logic rst_bit, logic [2:0] walls);
            logic [1:0] h;
            logic [1:0] dir_r;
            logic [1:0] dir_l;
            logic [1:0] target;
            logic [1:0] back;
            logic [1:0] turn;
            logic [1:0] st;
            logic [5:0] prev;
            bit         found;
            h      = heading;
            dir_r  = h + 2'd1;
            dir_l  = h + 2'd3;
            target = h;
            found  = 1'b0;
            if (rst_bit) begin
                reload();
                push_cmd(TURN_NONE, 1'b0, ST_EXPLORE);
                return;
            end
            if (phase == PH_FIN) begin
                push_cmd(TURN_NONE, 1'b0, ST_FINISHED);
                return;
            end
            if (phase != PH_RUN) begin
                push_cmd(TURN_NONE, 1'b0, ST_ERROR);
                return;
            end
            if (goal_done()) begin
                phase = PH_FIN;
                push_cmd(TURN_NONE, 1'b0, ST_FINISHED);
                return;
            end
            if (!walls[0] && can_enter(dir_r)) begin
                target = dir_r;
                found  = 1'b1;
            end else if (!walls[1] && can_enter(h)) begin
                target = h;
                found  = 1'b1;
            end else if (!walls[2] && can_enter(dir_l)) begin
                target = dir_l;
                found  = 1'b1;
            end
            if (found) begin
                if (stack_ptr < RETURN_DEPTH) begin
                    return_cells[stack_ptr] = {cur_x, cur_y};
                    stack_ptr++;
                end
                turn    = target - h;
                heading = target;
                move_ahead();
                visited = visited | cell_mask(cur_x, cur_y);
                if (visit_cnt < 7'd127)
                    visit_cnt = visit_cnt + 7'd1;
                st = ST_EXPLORE;
            end else begin
                if (stack_ptr == 0) begin
                    phase = PH_ERR;
                    push_cmd(TURN_NONE, 1'b0, ST_ERROR);
                    return;
                end
                stack_ptr--;
                prev = return_cells[stack_ptr];
                back = h;
                if (prev[5:3] > cur_x)
                    back = HD_EAST;
                else if (prev[5:3] < cur_x)
                    back = HD_WEST;
                else if (prev[2:0] > cur_y)
                    back = HD_NORTH;
                else if (prev[2:0] < cur_y)
                    back = HD_SOUTH;
                turn    = back - h;
                heading = back;
                move_ahead();
                st = ST_BACKTRACK;
            end
            if (goal_done()) begin
                phase = PH_FIN;
                st    = ST_FINISHED;
            end
            push_cmd(turn, 1'b1, st);
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned seen);
            if (want != seen) begin
                fail_count++;
                $error("%s: expected %0d, got %0d", name, want, seen);
            end
        endfunction

        function void check_command(logic [23:0] data);
            result_t want;
            if (expected_cmds.size() == 0) begin
                fail_count++;
                $error("command 0x%06h with no request outstanding", data);
                return;
            end
            want = expected_cmds.pop_front();
            compare_field("turn_cmd", want.turn_cmd, data[1:0]);
            compare_field("drive_cell", want.drive_cell, data[2]);
            compare_field("pos_x", want.pos_x, data[5:3]);
            compare_field("pos_y", want.pos_y, data[8:6]);
            compare_field("facing", want.facing, data[10:9]);
            compare_field("status", want.status, data[12:11]);
            compare_field("count_out", want.count_out, data[19:13]);
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;    // [2:0] walls, [7:3] zero
    logic        s_axis_tuser;    // [0] restart
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    // [1:0] turn_cmd, [2] drive_cell, [5:3] pos_x, [8:6] pos_y, [10:9] facing,
    // [12:11] status, [19:13] count_out, [23:20] zero
    logic [23:0] m_axis_tdata;
    logic        cfg_wr_en;
    logic [2:0]  cfg_index;
    logic [63:0] cfg_data;

    maze_scoreboard sb;
    int             burst_left;     // requests left in the current sender burst
    int             readings_done;  // requests that the explorer acts on
    logic [63:0]    reg_plan [8];   // register values for the next setup

    grid_dfs_explorer_unit i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop well beyond the slowest legal run (~1000 requests, each with
    // worst sender gap and receiver stall, plus the setup pauses).
    initial
    begin
        #3000000;
        $display("FAILED: results differ");
        $finish;
    end

    // Receiver: switches between always-ready, scattered stalls and long
    // stall runs, each mode held for a random stretch of cycles.
    initial
    begin
        int mode;
        int mode_left;
        int hold;
        mode          = 0;
        mode_left     = 0;
        hold          = 0;
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (mode_left == 0)
            begin
                mode      = $urandom_range(0, 2);
                mode_left = $urandom_range(20, 150);
            end
            mode_left--;
            case (mode)
                0: m_axis_tready = 1'b1;
                1: m_axis_tready = ($urandom_range(0, 2) != 0);
                default:
                begin
                    if (hold > 0)
                    begin
                        hold--;
                        m_axis_tready = 1'b0;
                    end
                    else if ($urandom_range(0, 5) == 0)
                    begin
                        hold          = $urandom_range(1, 8);
                        m_axis_tready = 1'b0;
                    end
                    else
                        m_axis_tready = 1'b1;
                end
            endcase
        end
    end

    // Result monitor: every accepted command is checked against the oldest
    // prediction.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && m_axis_tvalid && m_axis_tready)
                sb.check_command(m_axis_tdata);
        end
    end

    // One wall-reading request. Bursts of back-to-back requests are separated
    // by random gaps; the prediction is made at the accepting edge.
    task automatic send_reading(input logic rst_bit, input logic [2:0] walls);
        int gap;
        @(negedge clk);
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                s_axis_tvalid = 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        if (rst_bit || sb.phase == PH_RUN)
            readings_done++;
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {5'd0, walls};
        s_axis_tuser  = rst_bit;
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.note_reading(rst_bit, walls);
    endtask

    // Stop sending and wait until every predicted command has come back,
    // then let the pipeline settle.
    task automatic drain();
        @(negedge clk);
        s_axis_tvalid = 1'b0;
        burst_left    = 0;
        while (sb.expected_cmds.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Writes all registers from reg_plan, one per cycle, while idle.
    task automatic load_regs();
        for (int i = 0; i < 8; i++)
        begin
            @(negedge clk);
            cfg_wr_en = 1'b1;
            cfg_index = 3'(i);
            cfg_data  = reg_plan[i];
            @(posedge clk);
            sb.write_reg(3'(i), reg_plan[i]);
        end
        @(negedge clk);
        cfg_wr_en = 1'b0;
    endtask

    // Random arena setup; a few phases are pinned to degenerate sizes.
    task automatic random_setup(input int phase_no);
        int side;
        int lim;
        int pick;
        if (phase_no == 2)
            side = 0;
        else if (phase_no == 5)
            side = 1;
        else if ($urandom_range(0, 9) == 0)
            side = $urandom_range(9, 15);
        else
            side = $urandom_range(2, 8);
        lim = (side > 8) ? 8 : ((side == 0) ? 1 : side);
        reg_plan[REG_ARENA_SIZE] = 64'(side);
        reg_plan[REG_START_HEADING] = 64'($urandom_range(0, 3));
        if ($urandom_range(0, 9) == 0)
        begin
            reg_plan[REG_START_X] = 64'($urandom_range(0, 7));
            reg_plan[REG_START_Y] = 64'($urandom_range(0, 7));
        end
        else
        begin
            reg_plan[REG_START_X] = 64'($urandom_range(0, lim - 1));
            reg_plan[REG_START_Y] = 64'($urandom_range(0, lim - 1));
        end
        reg_plan[REG_GOAL_X] = 64'($urandom_range(0, lim - 1));
        reg_plan[REG_GOAL_Y] = 64'($urandom_range(0, lim - 1));
        pick = $urandom_range(0, 9);
        case (pick)
            0: reg_plan[REG_CELLS_TO_VISIT] = 64'd0;     // never finishes
            1: reg_plan[REG_CELLS_TO_VISIT] = 64'd127;
            2: reg_plan[REG_CELLS_TO_VISIT] = 64'd64;
            3: reg_plan[REG_CELLS_TO_VISIT] = 64'd1;
            default: reg_plan[REG_CELLS_TO_VISIT] = 64'($urandom_range(2, lim * lim));
        endcase
        pick = $urandom_range(0, 9);
        case (pick)
            0: reg_plan[REG_PREMARKED_CELLS] = 64'd0;
            1: reg_plan[REG_PREMARKED_CELLS] = '1;
            2: reg_plan[REG_PREMARKED_CELLS] = CFG_RST.premarked_cells;
            default:
                // sparse obstacles, about one cell in eight
                reg_plan[REG_PREMARKED_CELLS] = {$urandom & $urandom & $urandom,
                                                 $urandom & $urandom & $urandom};
        endcase
        load_regs();
    endtask

    initial
    begin
        logic [2:0] walls;
        logic       rst_bit;
        int         n_items;
        int         phase_no;

        sb            = new();
        burst_left    = 0;
        readings_done = 0;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 8'd0;
        s_axis_tuser  = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_index     = REG_ARENA_SIZE;
        cfg_data      = 64'd0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset defaults: a restart with walls set (ignored), boxed in at the
        // start so backtracking hits an empty stack, a halted request, then
        // every wall pattern from a fresh start.
        send_reading(1'b1, 3'b101);
        send_reading(1'b0, 3'b111);
        send_reading(1'b0, 3'b010);
        send_reading(1'b1, 3'b000);
        for (int w = 0; w < 8; w++)
            send_reading(1'b0, 3'(w));
        drain();

        // 2x2 arena with the goal refused until it is the last cell: the run
        // ends on the move into the goal, and the next request stays halted.
        reg_plan[REG_ARENA_SIZE]      = 64'd2;
        reg_plan[REG_START_X]         = 64'd0;
        reg_plan[REG_START_Y]         = 64'd0;
        reg_plan[REG_START_HEADING]   = 64'(HD_NORTH);
        reg_plan[REG_GOAL_X]          = 64'd1;
        reg_plan[REG_GOAL_Y]          = 64'd0;
        reg_plan[REG_CELLS_TO_VISIT]  = 64'd4;
        reg_plan[REG_PREMARKED_CELLS] = 64'd0;
        load_regs();
        send_reading(1'b1, 3'b000);
        repeat (4) send_reading(1'b0, 3'b000);
        drain();

        // Oversized arena, start on the goal with a count of one: finished
        // before the walls are looked at.
        reg_plan[REG_ARENA_SIZE]      = 64'd15;
        reg_plan[REG_START_X]         = 64'd7;
        reg_plan[REG_START_Y]         = 64'd7;
        reg_plan[REG_START_HEADING]   = 64'(HD_WEST);
        reg_plan[REG_GOAL_X]          = 64'd7;
        reg_plan[REG_GOAL_Y]          = 64'd7;
        reg_plan[REG_CELLS_TO_VISIT]  = 64'd1;
        reg_plan[REG_PREMARKED_CELLS] = '1;
        load_regs();
        send_reading(1'b1, 3'b000);
        send_reading(1'b0, 3'b000);
        send_reading(1'b0, 3'b111);
        drain();

        // Random phases: each starts from a restart, then mostly open wall
        // readings so the search runs deep; halted runs are usually restarted.
        phase_no = 0;
        while (readings_done < 900)
        begin
            random_setup(phase_no);
            send_reading(1'b1, 3'($urandom_range(0, 7)));
            n_items = $urandom_range(25, 45);
            for (int i = 0; i < n_items; i++)
            begin
                if ($urandom_range(0, 3) == 0)
                    walls = 3'($urandom_range(0, 7));
                else
                    walls = 3'($urandom & $urandom);
                rst_bit = (sb.phase != PH_RUN) ? ($urandom_range(0, 1) == 1)
                                               : ($urandom_range(0, 39) == 0);
                send_reading(rst_bit, walls);
            end
            drain();
            phase_no++;
        end

        repeat (20) @(posedge clk);
        if (sb.fail_count == 0 && sb.expected_cmds.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
